// ----- src/tpi_pkg.sv -----
// Shared types, widths and constants for the three-plane intersection block.
package tpi_pkg;

	// field widths
	localparam int NW = 16;                 // normal component width
	localparam int CW = 32;                 // offset and coordinate width
	localparam int NF = NW - 2;             // normal fraction bits
	localparam int THRESH_FRAC = 42;        // threshold register fraction bits
	localparam int THRESH_W = 32;           // threshold register width

	// intermediate widths
	localparam int PNW = 2 * NW;            // normal by normal product
	localparam int CRW = 2 * NW + 1;        // cross product component
	localparam int DPW = CRW + NW;          // cross by normal product
	localparam int DENW = DPW + 2;          // denominator
	localparam int NPW = CRW + CW;          // cross by offset product
	localparam int NUMW = NPW + 2;          // numerator
	localparam int DVW = NUMW + NF + 2;     // rounded dividend
	localparam int VW = DENW + 1;           // divisor, twice the denominator
	localparam int OW = DVW + 2;            // overflow compare width
	localparam int TW = DENW + THRESH_FRAC + THRESH_W; // threshold compare width

	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(43980465);

	// input transaction
	typedef struct packed {
		logic signed [NW-1:0] plane0_nx;
		logic signed [NW-1:0] plane0_ny;
		logic signed [NW-1:0] plane0_nz;
		logic signed [CW-1:0] plane0_d;
		logic signed [NW-1:0] plane1_nx;
		logic signed [NW-1:0] plane1_ny;
		logic signed [NW-1:0] plane1_nz;
		logic signed [CW-1:0] plane1_d;
		logic signed [NW-1:0] plane2_nx;
		logic signed [NW-1:0] plane2_ny;
		logic signed [NW-1:0] plane2_nz;
		logic signed [CW-1:0] plane2_d;
	} tpi_in_t;

	// result transaction
	typedef struct packed {
		logic                 found;
		logic                 saturated;
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		logic signed [CW-1:0] point_z;
	} tpi_out_t;

	// denominator and numerators leaving the geometry pipeline
	typedef struct packed {
		logic                       valid;
		logic signed [DENW-1:0]     den;
		logic [2:0][NUMW-1:0]       num;
	} tpi_geom_t;

	// one divider lane between bit stages
	typedef struct packed {
		logic           valid;
		logic           found;
		logic           neg;
		logic           ovf;
		logic [DVW-1:0] rem;
		logic [VW-1:0]  dvs;
		logic [CW-1:0]  quo;
	} tpi_div_t;

endpackage

// ----- src/three_plane_intersection.sv -----
// Top level: three-plane intersection point, fully pipelined.
//
// Usage:
//   Input channel: drive planes and raise start; the transaction is taken at
//   any clock edge with start high and busy low. busy is always low, so a new
//   transaction can enter every cycle.
//   Result channel: done is high for exactly one cycle with result valid;
//   results leave in input order and cannot be held off by the receiver.
//   Configuration: cfg_data is written to the zero threshold when cfg_valid
//   and cfg_ready are high; cfg_ready is always high. Write it only when no
//   transaction is in flight.
// Pipeline: 4 geometry stages, 1 setup stage, one stage per quotient bit
//   (32 at the default coordinate width) and 1 output stage.
// Throughput: one transaction per cycle, set by the bit-per-stage divider.
// Reset: clears all valid bits and loads the threshold reset value; no
//   results appear until new transactions arrive. No stall path exists.
module three_plane_intersection import tpi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tpi_in_t             planes,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [THRESH_W-1:0] cfg_data,
	output logic                done,
	output tpi_out_t            result
);

	localparam int LAT = 4 + 1 + CW + 1;

	logic [THRESH_W-1:0] thresh_q;
	tpi_geom_t           geom;

	logic [DENW-1:0]     aden;
	logic                found_c;
	logic [TW-1:0]       lhs, rhs;
	tpi_div_t            setup [3];
	tpi_div_t            lane [3][CW+1];   // lane[k][CW] enters at the top bit

	logic [NUMW-1:0]     anum [3];
	logic [DVW-1:0]      dividend [3];

	logic                done_q;
	tpi_out_t            result_q;
	logic [CW-1:0]       lim [3];
	logic [CW-1:0]       mag [3];
	logic [2:0]          clip;
	tpi_out_t            res_c;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thresh_q <= THRESH_RESET;
		else if (cfg_valid && cfg_ready)
			thresh_q <= cfg_data;
	end

	tpi_geom u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.planes   (planes),
		.geom     (geom)
	);

	// setup: magnitude, threshold test, rounded dividend, overflow check
	always_comb begin
		aden    = geom.den[DENW-1] ? DENW'(-geom.den) : geom.den;
		lhs     = TW'(aden) << THRESH_FRAC;
		rhs     = TW'(thresh_q) << (3 * NF);
		found_c = (geom.den != '0) && !(lhs < rhs);
		for (int k = 0; k < 3; k++) begin
			anum[k]     = geom.num[k][NUMW-1] ? NUMW'(-$signed(geom.num[k])) : geom.num[k];
			dividend[k] = (DVW'(anum[k]) << (NF + 1)) + DVW'(aden);
			setup[k].valid = geom.valid;
			setup[k].found = found_c;
			setup[k].neg   = geom.num[k][NUMW-1] ^ geom.den[DENW-1];
			setup[k].dvs   = {aden, 1'b0};
			setup[k].ovf   = OW'(dividend[k]) >= (OW'({aden, 1'b0}) << CW);
			setup[k].rem   = dividend[k];
			setup[k].quo   = '0;
		end
	end

	// setup stage registers
	logic [2:0]  setup_valid_s5;
	tpi_div_t    setup_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			setup_valid_s5 <= '0;
		else
			for (int k = 0; k < 3; k++)
				setup_valid_s5[k] <= setup[k].valid;
	end

	always_ff @(posedge clk) begin
		setup_s5 <= setup;
	end

	// divider lanes, most significant quotient bit first
	for (genvar k = 0; k < 3; k++) begin : g_lane
		always_comb begin
			lane[k][CW]       = setup_s5[k];
			lane[k][CW].valid = setup_valid_s5[k];
		end
		for (genvar b = CW - 1; b >= 0; b--) begin : g_bit
			tpi_div_stage #(.BIT(b)) u_stage (
				.clk      (clk),
				.arst_n   (arst_n),
				.lane_in  (lane[k][b+1]),
				.lane_out (lane[k][b])
			);
		end
	end

	// clip, apply sign, zero when degenerate
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lim[k]  = lane[k][0].neg ? (CW'(1) << (CW - 1)) : ((CW'(1) << (CW - 1)) - CW'(1));
			clip[k] = lane[k][0].ovf || (lane[k][0].quo > lim[k]);
			mag[k]  = clip[k] ? lim[k] : lane[k][0].quo;
		end
		res_c.found     = lane[0][0].found;
		res_c.saturated = lane[0][0].found && (clip != '0);
		res_c.point_x   = lane[0][0].neg ? -mag[0] : mag[0];
		res_c.point_y   = lane[1][0].neg ? -mag[1] : mag[1];
		res_c.point_z   = lane[2][0].neg ? -mag[2] : mag[2];
		if (!lane[0][0].found) begin
			res_c.point_x = '0;
			res_c.point_y = '0;
			res_c.point_z = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= lane[0][0].valid;
	end

	always_ff @(posedge clk) begin
		result_q <= res_c;
	end

	assign done   = done_q;
	assign result = result_q;

	// a transaction comes out a fixed number of cycles after it enters
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result missing after fixed latency");

	// degenerate planes carry no coordinates and no clip flag
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (!result.saturated && result.point_x == '0
			&& result.point_y == '0 && result.point_z == '0))
		else $error("degenerate result not cleared");

	// lanes stay in lock step through the divider
	a_lane_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(lane[0][0].valid == lane[1][0].valid) && (lane[0][0].valid == lane[2][0].valid))
		else $error("divider lanes out of step");

endmodule

// ----- src/tpi_geom.sv -----
// Four-stage pipeline: cross products, denominator and the three numerators.
module tpi_geom import tpi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  tpi_in_t   planes,
	output tpi_geom_t geom
);

	logic signed [NW-1:0] n [3][3];
	logic signed [CW-1:0] d [3];

	logic                  valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [PNW-1:0] prod_s1 [3][3][2];
	logic signed [NW-1:0]  n2_s1 [3];
	logic signed [CW-1:0]  d_s1 [3];
	logic signed [CRW-1:0] cr_s2 [3][3];   // [0]=n0xn1, [1]=n1xn2, [2]=n2xn0
	logic signed [NW-1:0]  n2_s2 [3];
	logic signed [CW-1:0]  d_s2 [3];
	logic signed [DPW-1:0] dprod_s3 [3];
	logic signed [NPW-1:0] nprod_s3 [3][3];
	logic signed [DENW-1:0] den_s4;
	logic signed [NUMW-1:0] num_s4 [3];

	always_comb begin
		n[0][0] = planes.plane0_nx; n[0][1] = planes.plane0_ny; n[0][2] = planes.plane0_nz;
		n[1][0] = planes.plane1_nx; n[1][1] = planes.plane1_ny; n[1][2] = planes.plane1_nz;
		n[2][0] = planes.plane2_nx; n[2][1] = planes.plane2_ny; n[2][2] = planes.plane2_nz;
		d[0] = planes.plane0_d;
		d[1] = planes.plane1_d;
		d[2] = planes.plane2_d;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// data path
	always_ff @(posedge clk) begin
		// s1: partial products of the cross products, pair p is n[p] x n[(p+1)%3]
		for (int p = 0; p < 3; p++) begin
			for (int k = 0; k < 3; k++) begin
				prod_s1[p][k][0] <= PNW'(n[p][(k+1)%3]) * PNW'(n[(p+1)%3][(k+2)%3]);
				prod_s1[p][k][1] <= PNW'(n[p][(k+2)%3]) * PNW'(n[(p+1)%3][(k+1)%3]);
			end
		end
		n2_s1 <= '{n[2][0], n[2][1], n[2][2]};
		d_s1  <= d;

		// s2: cross product components
		for (int p = 0; p < 3; p++)
			for (int k = 0; k < 3; k++)
				cr_s2[p][k] <= CRW'(prod_s1[p][k][0]) - CRW'(prod_s1[p][k][1]);
		n2_s2 <= n2_s1;
		d_s2  <= d_s1;

		// s3: denominator terms and numerator terms
		for (int k = 0; k < 3; k++) begin
			dprod_s3[k]    <= DPW'(cr_s2[0][k]) * DPW'(n2_s2[k]);
			nprod_s3[k][0] <= NPW'(cr_s2[1][k]) * NPW'(d_s2[0]);
			nprod_s3[k][1] <= NPW'(cr_s2[2][k]) * NPW'(d_s2[1]);
			nprod_s3[k][2] <= NPW'(cr_s2[0][k]) * NPW'(d_s2[2]);
		end

		// s4: sums
		den_s4 <= DENW'(dprod_s3[0]) + DENW'(dprod_s3[1]) + DENW'(dprod_s3[2]);
		for (int k = 0; k < 3; k++)
			num_s4[k] <= NUMW'(nprod_s3[k][0]) + NUMW'(nprod_s3[k][1])
				+ NUMW'(nprod_s3[k][2]);
	end

	always_comb begin
		geom.valid = valid_s4;
		geom.den   = den_s4;
		for (int k = 0; k < 3; k++)
			geom.num[k] = num_s4[k];
	end

endmodule

// ----- src/tpi_div_stage.sv -----
// One restoring-division stage: settles quotient bit BIT of one lane.
module tpi_div_stage import tpi_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  tpi_div_t lane_in,
	output tpi_div_t lane_out
);

	logic [DVW:0]   trial;
	tpi_div_t       nxt;
	logic           valid_q;
	tpi_div_t       data_q;

	// trial subtract of the divisor shifted to this bit
	always_comb begin
		nxt   = lane_in;
		trial = {1'b0, lane_in.rem} - ((DVW + 1)'(lane_in.dvs) << BIT);
		if (!trial[DVW]) begin
			nxt.rem      = trial[DVW-1:0];
			nxt.quo[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= lane_in.valid;
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	always_comb begin
		lane_out       = data_q;
		lane_out.valid = valid_q;
	end

endmodule

// ----- sim/three_plane_intersection_tb.sv -----
// Self-checking testbench for the three-plane intersection block.
`timescale 1ns / 100ps

module three_plane_intersection_tb;
	import tpi_pkg::*;

	typedef logic signed [127:0] wide_t;

	// directed stimulus row; expected value typed in only where chk is set
	typedef struct {
		tpi_in_t  p;
		bit       chk;
		tpi_out_t e;
	} stim_row_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PIPE_LAT = 38;
	localparam int Q16_ONE = 65536;
	localparam int N_ONE = 16384;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	tpi_in_t             planes;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [THRESH_W-1:0] cfg_data;
	logic                done;
	tpi_out_t            result;

	tpi_out_t            pending_points[$];
	logic [THRESH_W-1:0] thresh_shadow;
	int                  errors;
	int                  cycles;
	int                  sender_idle_pct;
	stim_row_t           rows[$];

	three_plane_intersection dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.planes    (planes),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// exact wide-integer intersection, rounded and clipped to Q15.16
	function automatic tpi_out_t solve_point(tpi_in_t p, logic [THRESH_W-1:0] thr);
		wide_t    n[3][3];
		wide_t    d[3];
		wide_t    c01[3], c12[3], c20[3];
		wide_t    den, aden, num, anum, q, lim, val;
		logic     neg;
		tpi_out_t r;
		n[0][0] = p.plane0_nx; n[0][1] = p.plane0_ny; n[0][2] = p.plane0_nz;
		n[1][0] = p.plane1_nx; n[1][1] = p.plane1_ny; n[1][2] = p.plane1_nz;
		n[2][0] = p.plane2_nx; n[2][1] = p.plane2_ny; n[2][2] = p.plane2_nz;
		d[0] = p.plane0_d; d[1] = p.plane1_d; d[2] = p.plane2_d;
		c01[0] = n[0][1] * n[1][2] - n[0][2] * n[1][1];
		c01[1] = n[0][2] * n[1][0] - n[0][0] * n[1][2];
		c01[2] = n[0][0] * n[1][1] - n[0][1] * n[1][0];
		c12[0] = n[1][1] * n[2][2] - n[1][2] * n[2][1];
		c12[1] = n[1][2] * n[2][0] - n[1][0] * n[2][2];
		c12[2] = n[1][0] * n[2][1] - n[1][1] * n[2][0];
		c20[0] = n[2][1] * n[0][2] - n[2][2] * n[0][1];
		c20[1] = n[2][2] * n[0][0] - n[2][0] * n[0][2];
		c20[2] = n[2][0] * n[0][1] - n[2][1] * n[0][0];
		den = c01[0] * n[2][0] + c01[1] * n[2][1] + c01[2] * n[2][2];
		aden = (den < 0) ? -den : den;
		r = '0;
		// both sides carry the same 2^42 scale, so compare directly
		if (den == 0 || aden < wide_t'({96'b0, thr}))
			return r;
		r.found = 1'b1;
		for (int k = 0; k < 3; k++) begin
			num = c12[k] * d[0] + c20[k] * d[1] + c01[k] * d[2];
			neg = (num < 0) != (den < 0);
			anum = (num < 0) ? -num : num;
			// round half away from zero
			q = ((anum <<< (NF + 1)) + aden) / (aden <<< 1);
			lim = neg ? 128'sh80000000 : 128'sh7FFFFFFF;
			if (q > lim) begin
				q = lim;
				r.saturated = 1'b1;
			end
			val = neg ? -q : q;
			case (k)
				0: r.point_x = val[CW-1:0];
				1: r.point_y = val[CW-1:0];
				default: r.point_z = val[CW-1:0];
			endcase
		end
		return r;
	endfunction

	function automatic tpi_in_t mk_planes(int a0, int a1, int a2, int ad,
			int b0, int b1, int b2, int bd, int c0, int c1, int c2, int cd);
		tpi_in_t p;
		p.plane0_nx = a0[NW-1:0]; p.plane0_ny = a1[NW-1:0];
		p.plane0_nz = a2[NW-1:0]; p.plane0_d = ad;
		p.plane1_nx = b0[NW-1:0]; p.plane1_ny = b1[NW-1:0];
		p.plane1_nz = b2[NW-1:0]; p.plane1_d = bd;
		p.plane2_nx = c0[NW-1:0]; p.plane2_ny = c1[NW-1:0];
		p.plane2_nz = c2[NW-1:0]; p.plane2_d = cd;
		return p;
	endfunction

	function automatic logic [NW-1:0] rand_normal(int mode);
		case (mode)
			0: return NW'($urandom);
			1: return NW'($urandom_range(0, 64)) - NW'(32);
			default: return NW'($urandom_range(0, 2 * N_ONE)) - NW'(N_ONE);
		endcase
	endfunction

	function automatic tpi_in_t rand_planes();
		int      nm, dm;
		tpi_in_t p;
		nm = $urandom_range(0, 5);
		dm = $urandom_range(0, 2);
		p = '0;
		p.plane0_d = $urandom; p.plane1_d = $urandom; p.plane2_d = $urandom;
		p.plane0_nx = rand_normal(nm); p.plane0_ny = rand_normal(nm);
		p.plane0_nz = rand_normal(nm); p.plane1_nx = rand_normal(nm);
		p.plane1_ny = rand_normal(nm); p.plane1_nz = rand_normal(nm);
		p.plane2_nx = rand_normal(nm); p.plane2_ny = rand_normal(nm);
		p.plane2_nz = rand_normal(nm);
		// occasionally make plane2 a copy of plane0: degenerate
		if ($urandom_range(0, 9) == 0) begin
			p.plane2_nx = p.plane0_nx; p.plane2_ny = p.plane0_ny;
			p.plane2_nz = p.plane0_nz;
		end
		if (dm == 0) begin
			p.plane0_d = $urandom_range(0, 1 << 20) - (1 << 19);
			p.plane1_d = $urandom_range(0, 1 << 20) - (1 << 19);
			p.plane2_d = $urandom_range(0, 1 << 20) - (1 << 19);
		end
		return p;
	endfunction

	// present one transaction and hold until it is taken
	task automatic send_planes(tpi_in_t p, bit use_typed, tpi_out_t typed);
		planes <= p;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_points.push_back(use_typed ? typed : solve_point(p, thresh_shadow));
		if ($urandom_range(1, 100) <= sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic write_threshold(logic [THRESH_W-1:0] v);
		start <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		thresh_shadow = v;
	endtask

	// result checker
	always @(posedge clk) begin
		tpi_out_t want;
		if (arst_n && done) begin
			if (pending_points.size() == 0) begin
				$display("%0t: unexpected result %p", $time, result);
				errors++;
			end else begin
				want = pending_points.pop_front();
				if (result.found !== want.found || result.saturated !== want.saturated ||
						result.point_x !== want.point_x ||
						result.point_y !== want.point_y ||
						result.point_z !== want.point_z) begin
					$display("%0t: mismatch expected %p actual %p", $time, want, result);
					errors++;
				end
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		tpi_out_t r0, rx, rsp, rsn;
		logic [THRESH_W-1:0] thr_set[5];
		errors = 0;
		cycles = 0;
		sender_idle_pct = 0;
		thresh_shadow = THRESH_RESET;
		arst_n = 1'b0;
		start = 1'b0;
		planes = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;

		r0 = '0;
		rx = '{found: 1'b1, saturated: 1'b0, point_x: Q16_ONE,
			point_y: 2 * Q16_ONE, point_z: 3 * Q16_ONE};
		rsp = '{found: 1'b1, saturated: 1'b1, point_x: 32'h7FFFFFFF,
			point_y: 0, point_z: 0};
		rsn = '{found: 1'b1, saturated: 1'b1, point_x: 32'h80000000,
			point_y: 0, point_z: 0};
		rows.push_back('{mk_planes(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, r0});
		rows.push_back('{mk_planes(N_ONE, 0, 0, Q16_ONE, 0, N_ONE, 0, 2 * Q16_ONE,
			0, 0, N_ONE, 3 * Q16_ONE), 1'b1, rx});
		// x = 4 / 2^-14 lies far outside the coordinate range
		rows.push_back('{mk_planes(1, 0, 0, 4 * Q16_ONE, 0, N_ONE, 0, 0,
			0, 0, N_ONE, 0), 1'b1, rsp});
		rows.push_back('{mk_planes(1, 0, 0, -4 * Q16_ONE, 0, N_ONE, 0, 0,
			0, 0, N_ONE, 0), 1'b1, rsn});
		// parallel planes: zero denominator
		rows.push_back('{mk_planes(N_ONE, 0, 0, 5, N_ONE, 0, 0, 7,
			0, 0, N_ONE, 3), 1'b1, r0});
		rows.push_back('{mk_planes(-32768, -32768, -32768, 32'sh80000000,
			-32768, 32767, -32768, 32'sh7FFFFFFF, 32767, -32768, -32768,
			32'sh80000000), 1'b0, r0});
		rows.push_back('{mk_planes(32767, -32768, 0, 32'sh7FFFFFFF, 0, 32767, -32768,
			32'sh80000000, -32768, 0, 32767, 32'sh7FFFFFFF), 1'b0, r0});
		rows.push_back('{mk_planes(-32768, 0, 0, 32'sh7FFFFFFF, 0, -32768, 0, -1,
			0, 0, -32768, 1), 1'b0, r0});
		// unnormalized normals and half-step rounding
		rows.push_back('{mk_planes(3 * N_ONE / 2, 100, -7, 3, -200, N_ONE / 3, 9, -1,
			11, -13, 2 * N_ONE - 1, 1), 1'b0, r0});
		rows.push_back('{mk_planes(N_ONE * 2, 0, 0, 1, 0, N_ONE * 2, 0, -1,
			0, 0, N_ONE * 2, 3), 1'b0, r0});
		// tiny denominators below the reset threshold
		rows.push_back('{mk_planes(40, 0, 0, 100, 0, 40, 0, 200, 0, 0, 40, 300), 1'b0, r0});
		rows.push_back('{mk_planes(20, 0, 0, 100, 0, 20, 0, 200, 0, 0, 20, 300), 1'b0, r0});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset threshold
		foreach (rows[i])
			send_planes(rows[i].p, rows[i].chk, rows[i].e);

		// zero threshold: only an exact zero denominator is degenerate
		write_threshold('0);
		send_planes(rows[4].p, 1'b1, r0);
		send_planes(rows[11].p, 1'b0, r0);

		// random phases across threshold settings and sender pacing
		thr_set[0] = THRESH_RESET;
		thr_set[1] = '1;
		thr_set[2] = 32'd1;
		thr_set[3] = $urandom_range(0, 1 << 30);
		thr_set[4] = '0;
		for (int ph = 0; ph < 5; ph++) begin
			write_threshold(thr_set[ph]);
			if (ph == 4)
				sender_idle_pct = 7;
			else
				sender_idle_pct = (ph % 2 == 1) ? 65 : 0;
			repeat (ph == 1 ? 50 : 125)
				send_planes(rand_planes(), 1'b0, r0);
		end

		start <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/tpi_pkg.sv
src/tpi_geom.sv
src/tpi_div_stage.sv
src/three_plane_intersection.sv
sim/three_plane_intersection_tb.sv
